// ----- src/tgs_pkg.sv -----
// ----------------------------------------------------------------------------
// tgs_pkg
// Types, codes and result builders for the transfer group sequencer.
// ----------------------------------------------------------------------------
package tgs_pkg;

  localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
  localparam logic [1:0] CMD_FINISHED = 2'd1;
  localparam logic [1:0] CMD_DETACH   = 2'd2;
  localparam logic [1:0] CMD_ATTACH   = 2'd3;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [1:0] ST_COMPLETED = 2'd0;
  localparam logic [1:0] ST_REJECTED  = 2'd1;
  localparam logic [1:0] ST_STOPPED   = 2'd2;
  localparam logic [1:0] ST_ABORTED   = 2'd3;

  localparam int unsigned CFG_W = 5;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] group_id;
    logic [7:0]  transfer_count;
    logic        continue_on_error;
    logic [7:0]  finished_tag;
    logic        transfer_passed;
    logic        device_fault;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] out_group;
    logic [7:0]  transfer_index;
    logic [7:0]  start_tag;
    logic [1:0]  finish_status;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REJECT,
    S_READ,
    S_EVAL
  } state_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_STOP,
    OP_ABORT
  } op_t;

  function automatic out_item_t make_finish(input logic [15:0] gid,
                                            input logic [1:0] status,
                                            input logic is_last);
    out_item_t r;
    r.kind           = KIND_FINISH;
    r.out_group      = gid;
    r.transfer_index = 8'd0;
    r.start_tag      = 8'd0;
    r.finish_status  = status;
    r.last           = is_last;
    return r;
  endfunction

  function automatic out_item_t make_start(input logic [15:0] gid,
                                           input logic [7:0] idx,
                                           input logic [7:0] tag);
    out_item_t r;
    r.kind           = KIND_START;
    r.out_group      = gid;
    r.transfer_index = idx;
    r.start_tag      = tag;
    r.finish_status  = ST_COMPLETED;
    r.last           = 1'b1;
    return r;
  endfunction

endpackage

// ----- src/transfer_group_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// transfer_group_sequencer_unit
// Queue of transfer groups; starts one transfer at a time, reports finishes.
// ----------------------------------------------------------------------------
// An enqueue into a queue whose head transfer is already running is taken
// straight in the idle state. Any command that makes the block look at the
// head group handles each group visited with a slot memory read, then one
// compare in the shared evaluation step; a failed transfer in a group that
// continues on error is evaluated again as a start in that step. Starting a
// transfer from the head group after an enqueue or a finish passes through
// the read and evaluation steps, a rejected enqueue through the reject step,
// and an abort visits every queued group, up to min(QUEUE_DEPTH, 16). A step
// that emits a result waits while the output register is still held; the next
// item is accepted while the last result waits to be taken.
module transfer_group_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned MAX_TRANSFERS = 255
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tgs_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tgs_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tgs_pkg::out_item_t        out_data
);
  import tgs_pkg::*;

  localparam int unsigned CAP   = (QUEUE_DEPTH < 16) ? QUEUE_DEPTH : 16;
  localparam int unsigned PTR_W = $clog2(CAP);
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  // slot memory
  logic [15:0] ids    [CAP];
  logic [7:0]  counts [CAP];
  logic        modes  [CAP];

  logic [15:0] rd_id;
  logic [7:0]  rd_count;
  logic        rd_mode;

  state_t            state, state_next;
  op_t               op, op_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  occ, occ_next;
  logic [7:0]        pos, pos_next;
  logic              busy, busy_next;
  logic [7:0]        tag, tag_next;
  logic              dev_open, dev_open_next;
  logic [CFG_W-1:0]  pending_limit;
  logic [15:0]       hold_gid, hold_gid_next;
  logic              out_valid_next;
  out_item_t         out_data_next;

  logic              wr_en;
  logic [PTR_W-1:0]  tail;
  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  head_inc;
  logic              enq_ok;
  logic              out_free;
  logic              last_group;
  logic              pop;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign last_group = (occ == CNT_W'(1));

  assign tail_sum = SUM_W'(head) + SUM_W'(occ);
  assign tail     = (tail_sum >= SUM_W'(CAP)) ? PTR_W'(tail_sum - SUM_W'(CAP))
                                              : PTR_W'(tail_sum);
  assign head_inc = (head == PTR_W'(CAP - 1)) ? '0 : head + PTR_W'(1);

  assign enq_ok = dev_open
                  && (in_data.transfer_count != 8'd0)
                  && (32'(in_data.transfer_count) <= MAX_TRANSFERS)
                  && ((pending_limit == '0) || (CFG_W'(occ) < pending_limit))
                  && (occ < CNT_W'(CAP));

  always_comb begin
    state_next     = state;
    op_next        = op;
    head_next      = head;
    occ_next       = occ;
    pos_next       = pos;
    busy_next      = busy;
    tag_next       = tag;
    dev_open_next  = dev_open;
    hold_gid_next  = hold_gid;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    wr_en          = 1'b0;
    in_ready       = 1'b0;
    pop            = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_data.command)
            CMD_ENQUEUE: begin
              if (!enq_ok) begin
                hold_gid_next = in_data.group_id;
                state_next    = S_REJECT;
              end else begin
                wr_en    = 1'b1;
                occ_next = occ + CNT_W'(1);
                op_next  = OP_START;
                if (!busy) state_next = S_READ;
              end
            end
            CMD_FINISHED: begin
              if (busy && in_data.finished_tag == tag) begin
                busy_next = 1'b0;
                if (occ != '0) begin
                  state_next = S_READ;
                  if (in_data.device_fault) op_next = OP_ABORT;
                  else if (!in_data.transfer_passed) op_next = OP_STOP;
                  else op_next = OP_START;
                end
              end
            end
            CMD_DETACH: begin
              busy_next     = 1'b0;
              dev_open_next = 1'b0;
              if (occ != '0) begin
                op_next    = OP_ABORT;
                state_next = S_READ;
              end
            end
            CMD_ATTACH: begin
              dev_open_next = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_REJECT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = make_finish(hold_gid, ST_REJECTED, 1'b1);
          state_next     = S_IDLE;
        end
      end

      S_READ: begin
        state_next = S_EVAL;
      end

      S_EVAL: begin
        if (out_free) begin
          unique case (op)
            OP_ABORT: begin
              out_valid_next = 1'b1;
              out_data_next  = make_finish(rd_id, ST_ABORTED, last_group);
              pop            = 1'b1;
            end
            OP_STOP: begin
              op_next = OP_START;
              if (!rd_mode) begin
                out_valid_next = 1'b1;
                out_data_next  = make_finish(rd_id, ST_STOPPED, last_group);
                pop            = 1'b1;
              end
            end
            OP_START: begin
              out_valid_next = 1'b1;
              if (pos < rd_count) begin
                out_data_next = make_start(rd_id, pos, tag + 8'd1);
                tag_next      = tag + 8'd1;
                pos_next      = pos + 8'd1;
                busy_next     = 1'b1;
                state_next    = S_IDLE;
              end else begin
                out_data_next = make_finish(rd_id, ST_COMPLETED, last_group);
                pop           = 1'b1;
              end
            end
            default: ;
          endcase
          if (pop) begin
            head_next  = head_inc;
            occ_next   = occ - CNT_W'(1);
            pos_next   = 8'd0;
            state_next = last_group ? S_IDLE : S_READ;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op            <= OP_START;
      head          <= '0;
      occ           <= '0;
      pos           <= 8'd0;
      busy          <= 1'b0;
      tag           <= 8'd0;
      dev_open      <= 1'b0;
      pending_limit <= '0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      head      <= head_next;
      occ       <= occ_next;
      pos       <= pos_next;
      busy      <= busy_next;
      tag       <= tag_next;
      dev_open  <= dev_open_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) pending_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    hold_gid <= hold_gid_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ids[tail]    <= in_data.group_id;
      counts[tail] <= in_data.transfer_count;
      modes[tail]  <= in_data.continue_on_error;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_id    <= ids[head];
      rd_count <= counts[head];
      rd_mode  <= modes[head];
    end
  end

endmodule
